[design/hrl_pkg.sv]
// ============================================================================
// hrl_pkg
// Shared constants for the hue rotation RGB LED drive unit: field widths,
// angle folding points, trig table build constants and register map.
// ============================================================================
package hrl_pkg;

    // Payload widths
    localparam int LEVEL_W  = 8;
    localparam int DIRECT_W = 16;
    localparam int HUE_W    = 9;
    localparam int BR_W     = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // Operation codes
    localparam logic OP_DIRECT = 1'b0;
    localparam logic OP_HUE    = 1'b1;

    // Angle folding points in whole degrees
    localparam logic [HUE_W-1:0] HUE_Q1   = 9'd90;
    localparam logic [HUE_W-1:0] HUE_Q2   = 9'd180;
    localparam logic [HUE_W-1:0] HUE_Q3   = 9'd270;
    localparam logic [HUE_W-1:0] HUE_FULL = 9'd360;

    // Trig table: index 0..90 degrees, built in Q28 at elaboration
    localparam int          TAB_IDX_W = 7;
    localparam int          Q28_BITS  = 28;
    localparam int          TAYLOR_N  = 10;
    localparam logic [63:0] PI_Q28    = 64'd843314857;
    localparam logic [63:0] Q28_ONE   = 64'd1 << Q28_BITS;
    // sin(60) serves as sqrt(3)/2
    localparam logic [TAB_IDX_W-1:0] K_DEG = 7'd60;

    // Configuration port
    localparam int   ADDR_W   = 3;
    localparam int   APB_DW   = 32;
    localparam logic REG_COMMON_CATHODE = 1'b0;  // word index

endpackage

[design/hrl_trig.sv]
// ============================================================================
// hrl_trig
// Folds a hue angle into the first quadrant and looks up signed cosine and
// sine with TRIG_FRAC_BITS fraction bits; results are registered on load.
// ============================================================================
module hrl_trig #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [hrl_pkg::HUE_W-1:0]   i_hue,
    output logic signed [TRIG_FRAC_BITS+1:0] o_cos,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sin,
    output logic [TRIG_FRAC_BITS:0]     o_k
);
    import hrl_pkg::*;

    localparam int F         = TRIG_FRAC_BITS;
    localparam int TAB_DEPTH = 1 << TAB_IDX_W;

    typedef logic [F:0] t_tab [0:TAB_DEPTH-1];

    function automatic t_tab f_build(input logic want_sin);
        t_tab        tab;
        logic [63:0] x;
        logic [63:0] ct;
        logic [63:0] cs;
        logic [63:0] st;
        logic [63:0] ss;
        logic [63:0] v;
        int          d;
        int          k;
        for (d = 0; d < TAB_DEPTH; d++) begin
            tab[d] = '0;
            if (d <= int'(HUE_Q1)) begin
                x  = (64'(d) * PI_Q28 + 64'd90) / 64'd180;
                ct = Q28_ONE;
                cs = Q28_ONE;
                st = x;
                ss = x;
                for (k = 1; k <= TAYLOR_N; k++) begin
                    ct = ((ct * x) >> Q28_BITS) / 64'((2 * k - 1) * (2 * k));
                    st = ((st * x) >> Q28_BITS) / 64'((2 * k) * (2 * k + 1));
                    if (k[0]) begin
                        cs = cs - ct;
                        ss = ss - st;
                    end else begin
                        cs = cs + ct;
                        ss = ss + st;
                    end
                end
                v = want_sin ? ss : cs;
                // wrapped below zero reads as zero, then clamp to one
                if (v > (64'd1 << 63)) v = '0;
                if (v > Q28_ONE) v = Q28_ONE;
                v = (v + (64'd1 << (Q28_BITS - 1 - F))) >> (Q28_BITS - F);
                tab[d] = v[F:0];
            end
        end
        return tab;
    endfunction

    localparam t_tab COS_TAB = f_build(1'b0);
    localparam t_tab SIN_TAB = f_build(1'b1);

    logic [HUE_W-1:0]     w_ang;
    logic [HUE_W-1:0]     w_idx_full;
    logic [TAB_IDX_W-1:0] w_idx;
    logic                 w_cos_neg;
    logic                 w_sin_neg;
    logic signed [F+1:0]  w_cos_mag;
    logic signed [F+1:0]  w_sin_mag;
    logic signed [F+1:0]  r_cos;
    logic signed [F+1:0]  r_sin;

    // 360 and above wrap once; the input never reaches 720
    assign w_ang = (i_hue >= HUE_FULL) ? i_hue - HUE_FULL : i_hue;

    always_comb begin
        priority if (w_ang <= HUE_Q1) begin
            w_idx_full = w_ang;
            w_cos_neg  = 1'b0;
            w_sin_neg  = 1'b0;
        end else if (w_ang <= HUE_Q2) begin
            w_idx_full = HUE_Q2 - w_ang;
            w_cos_neg  = 1'b1;
            w_sin_neg  = 1'b0;
        end else if (w_ang <= HUE_Q3) begin
            w_idx_full = w_ang - HUE_Q2;
            w_cos_neg  = 1'b1;
            w_sin_neg  = 1'b1;
        end else begin
            w_idx_full = HUE_FULL - w_ang;
            w_cos_neg  = 1'b0;
            w_sin_neg  = 1'b1;
        end
    end

    assign w_idx     = w_idx_full[TAB_IDX_W-1:0];
    assign w_cos_mag = signed'({1'b0, COS_TAB[w_idx]});
    assign w_sin_mag = signed'({1'b0, SIN_TAB[w_idx]});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cos <= w_cos_neg ? -w_cos_mag : w_cos_mag;
            r_sin <= w_sin_neg ? -w_sin_mag : w_sin_mag;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
    assign o_k   = SIN_TAB[K_DEG];

endmodule

[design/hrl_mul.sv]
// ============================================================================
// hrl_mul
// Shared signed multiplier with a registered product, issued by the
// sequencer once per step.
// ============================================================================
module hrl_mul #(
    parameter int A_W = 30,
    parameter int B_W = 16
) (
    input  logic                       i_clk,
    input  logic                       i_go,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [B_W-1:0]      i_b,
    output logic signed [A_W+B_W-1:0]  o_prod
);
    logic signed [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_prod <= (A_W + B_W)'(i_a) * (A_W + B_W)'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

[design/hue_rotate_rgb_led_drive_unit.sv]
// ============================================================================
// hue_rotate_rgb_led_drive_unit
// Turns a direct colour or a hue angle with brightness into three saturated
// LED levels with polarity, and flags the channels whose level changed.
// ============================================================================
// Sequencing: a direct colour goes straight to the final step, which registers
//   the result valid; a hue rotation first makes four passes through one multiplier.
// A new item is taken only when the previous one has left the final step; a
//   waiting result holds the final step.
// Reset: synchronous active low; clears the sequencer, the result valid and
//   the stored levels, and sets common_cathode to 1.
module hue_rotate_rgb_led_drive_unit #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic signed [hrl_pkg::DIRECT_W-1:0] i_red_in,
    input  logic signed [hrl_pkg::DIRECT_W-1:0] i_green_in,
    input  logic signed [hrl_pkg::DIRECT_W-1:0] i_blue_in,
    input  logic [hrl_pkg::HUE_W-1:0]          i_hue_degrees,
    input  logic [hrl_pkg::BR_W-1:0]           i_brightness,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [hrl_pkg::LEVEL_W-1:0]        o_red_level,
    output logic [hrl_pkg::LEVEL_W-1:0]        o_green_level,
    output logic [hrl_pkg::LEVEL_W-1:0]        o_blue_level,
    output logic                               o_red_changed,
    output logic                               o_green_changed,
    output logic                               o_blue_changed,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hrl_pkg::ADDR_W-1:0]         paddr,
    input  logic [hrl_pkg::APB_DW-1:0]         pwdata,
    output logic [hrl_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import hrl_pkg::*;

    localparam int F  = TRIG_FRAC_BITS;
    localparam int WA = 2 * F + 2;
    localparam int WB = F + 2;
    localparam int WP = WA + WB;

    localparam logic signed [WA-1:0] ONE_A  = WA'(64'd1 << F);
    localparam logic signed [WA-1:0] HALF_A = WA'(64'd1 << (F - 1));

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KS   = 3'd1;
    localparam logic [2:0] ST_GRN  = 3'd2;
    localparam logic [2:0] ST_BLU  = 3'd3;
    localparam logic [2:0] ST_RED  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    function automatic logic [LEVEL_W-1:0] f_sat_direct(
        input logic signed [DIRECT_W-1:0] v
    );
        logic [LEVEL_W-1:0] u;
        if (v[DIRECT_W-1]) u = '0;
        else if (|v[DIRECT_W-2:LEVEL_W]) u = LEVEL_MAX;
        else u = v[LEVEL_W-1:0];
        return u;
    endfunction

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic                r_cc;
    logic                r_op;
    logic [BR_W-1:0]     r_br;
    logic [LEVEL_W-1:0]  r_lvl_r;
    logic [LEVEL_W-1:0]  r_lvl_g;
    logic [LEVEL_W-1:0]  r_lvl_b;
    logic signed [WA-1:0] r_ks;
    logic [LEVEL_W-1:0]  r_last_r;
    logic [LEVEL_W-1:0]  r_last_g;
    logic [LEVEL_W-1:0]  r_last_b;
    logic                r_chg_r;
    logic                r_chg_g;
    logic                r_chg_b;
    logic                r_out_valid;

    logic                w_in_xfer;
    logic                w_cfg_wr;
    logic                w_fin_go;
    logic signed [F+1:0] w_cos;
    logic signed [F+1:0] w_sin;
    logic [F:0]          w_k;
    logic signed [WA-1:0] w_cos_a;
    logic signed [WA-1:0] w_base;
    logic signed [WA-1:0] w_ks_now;
    logic signed [WA-1:0] w_sum_g;
    logic signed [WA-1:0] w_sum_b;
    logic signed [WA-1:0] w_sum_r;
    logic signed [WB-1:0] w_br_b;
    logic                w_mul_go;
    logic signed [WA-1:0] w_mul_a;
    logic signed [WB-1:0] w_mul_b;
    logic signed [WP-1:0] w_prod;
    logic [LEVEL_W-1:0]  w_prod_lvl;
    logic [LEVEL_W-1:0]  w_raw_r;
    logic [LEVEL_W-1:0]  w_pol_r;
    logic [LEVEL_W-1:0]  w_pol_g;
    logic [LEVEL_W-1:0]  w_pol_b;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_fin_go   = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[ADDR_W-1] == REG_COMMON_CATHODE);
    assign prdata   = (paddr[ADDR_W-1] == REG_COMMON_CATHODE) ? APB_DW'(r_cc) : '0;

    hrl_trig #(
        .TRIG_FRAC_BITS (F)
    ) u_trig (
        .i_clk  (i_clk),
        .i_load (w_in_xfer),
        .i_hue  (i_hue_degrees),
        .o_cos  (w_cos),
        .o_sin  (w_sin),
        .o_k    (w_k)
    );

    // channel sums in Q(2F)
    assign w_cos_a  = WA'(w_cos);
    assign w_base   = (ONE_A - w_cos_a) <<< (F - 1);
    assign w_ks_now = w_prod[WA-1:0];
    assign w_sum_g  = w_base + w_ks_now;
    assign w_sum_b  = w_base - r_ks;
    assign w_sum_r  = (HALF_A + w_cos_a) <<< F;
    assign w_br_b   = WB'(signed'({1'b0, r_br}));

    always_comb begin
        unique case (r_state)
            ST_KS: begin
                w_mul_go = 1'b1;
                w_mul_a  = WA'(w_sin);
                w_mul_b  = signed'({1'b0, w_k});
            end
            ST_GRN: begin
                w_mul_go = 1'b1;
                w_mul_a  = w_sum_g;
                w_mul_b  = w_br_b;
            end
            ST_BLU: begin
                w_mul_go = 1'b1;
                w_mul_a  = w_sum_b;
                w_mul_b  = w_br_b;
            end
            ST_RED: begin
                w_mul_go = 1'b1;
                w_mul_a  = w_sum_r;
                w_mul_b  = w_br_b;
            end
            default: begin
                w_mul_go = 1'b0;
                w_mul_a  = '0;
                w_mul_b  = '0;
            end
        endcase
    end

    hrl_mul #(
        .A_W (WA),
        .B_W (WB)
    ) u_mul (
        .i_clk  (i_clk),
        .i_go   (w_mul_go),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // drop 2F fraction bits; anything negative saturates to zero anyway
    always_comb begin
        if (w_prod[WP-1]) w_prod_lvl = '0;
        else if (|w_prod[WP-2:2*F+LEVEL_W]) w_prod_lvl = LEVEL_MAX;
        else w_prod_lvl = w_prod[2*F+LEVEL_W-1:2*F];
    end

    assign w_raw_r = (r_op == OP_HUE) ? w_prod_lvl : r_lvl_r;
    assign w_pol_r = r_cc ? w_raw_r : LEVEL_MAX - w_raw_r;
    assign w_pol_g = r_cc ? r_lvl_g : LEVEL_MAX - r_lvl_g;
    assign w_pol_b = r_cc ? r_lvl_b : LEVEL_MAX - r_lvl_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) n_state = (i_op == OP_DIRECT) ? ST_FIN : ST_KS;
            end
            ST_KS:  n_state = ST_GRN;
            ST_GRN: n_state = ST_BLU;
            ST_BLU: n_state = ST_RED;
            ST_RED: n_state = ST_FIN;
            ST_FIN: begin
                if (w_fin_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cc        <= 1'b1;
            r_out_valid <= 1'b0;
            r_last_r    <= '0;
            r_last_g    <= '0;
            r_last_b    <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) r_cc <= pwdata[0];
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
                r_last_r    <= w_pol_r;
                r_last_g    <= w_pol_g;
                r_last_b    <= w_pol_b;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op    <= i_op;
            r_br    <= i_brightness;
            r_lvl_r <= f_sat_direct(i_red_in);
            r_lvl_g <= f_sat_direct(i_green_in);
            r_lvl_b <= f_sat_direct(i_blue_in);
        end
        if (r_state == ST_GRN) r_ks    <= w_ks_now;
        if (r_state == ST_BLU) r_lvl_g <= w_prod_lvl;
        if (r_state == ST_RED) r_lvl_b <= w_prod_lvl;
        if (w_fin_go) begin
            r_chg_r <= (w_pol_r != r_last_r);
            r_chg_g <= (w_pol_g != r_last_g);
            r_chg_b <= (w_pol_b != r_last_b);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_red_level     = r_last_r;
    assign o_green_level   = r_last_g;
    assign o_blue_level    = r_last_b;
    assign o_red_changed   = r_chg_r;
    assign o_green_changed = r_chg_g;
    assign o_blue_changed  = r_chg_b;

endmodule

[design/hrl_chk.sv]
// ============================================================================
// hrl_chk
// Port-level checks for the hue rotation LED drive unit, bound to the top.
// ============================================================================
module hrl_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [hrl_pkg::LEVEL_W-1:0]  o_red_level,
    input logic [hrl_pkg::LEVEL_W-1:0]  o_green_level,
    input logic [hrl_pkg::LEVEL_W-1:0]  o_blue_level,
    input logic                         o_red_changed,
    input logic                         o_green_changed,
    input logic                         o_blue_changed,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [hrl_pkg::ADDR_W-1:0]   paddr,
    input logic [hrl_pkg::APB_DW-1:0]   pwdata,
    input logic [hrl_pkg::APB_DW-1:0]   prdata
);
    import hrl_pkg::*;

    logic [LEVEL_W-1:0] r_prev_r;
    logic [LEVEL_W-1:0] r_prev_g;
    logic [LEVEL_W-1:0] r_prev_b;
    logic               w_out_xfer;
    logic               w_cc_wr;

    assign w_out_xfer = o_out_valid && i_out_ready;
    assign w_cc_wr    = psel && penable && pwrite
                        && (paddr[ADDR_W-1] == REG_COMMON_CATHODE);

    // track the levels of the last result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_r <= '0;
            r_prev_g <= '0;
            r_prev_b <= '0;
        end else if (w_out_xfer) begin
            r_prev_r <= o_red_level;
            r_prev_g <= o_green_level;
            r_prev_b <= o_blue_level;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red_level)
            && $stable(o_green_level) && $stable(o_blue_level))
        else $error("pending result dropped or changed");

    a_changed_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_red_level != r_prev_r) == o_red_changed)
            && ((o_green_level != r_prev_g) == o_green_changed)
            && ((o_blue_level != r_prev_b) == o_blue_changed))
        else $error("changed flag disagrees with previous level");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(w_cc_wr)
            && (paddr[ADDR_W-1] == REG_COMMON_CATHODE)
            && !(w_cc_wr && (pwdata[0] != $past(pwdata[0])))
            |-> prdata[0] == $past(pwdata[0]))
        else $error("common_cathode readback mismatch");

endmodule

bind hue_rotate_rgb_led_drive_unit hrl_chk u_hrl_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_red_level     (o_red_level),
    .o_green_level   (o_green_level),
    .o_blue_level    (o_blue_level),
    .o_red_changed   (o_red_changed),
    .o_green_changed (o_green_changed),
    .o_blue_changed  (o_blue_changed),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
);

[dv/tb_hue_rotate_rgb_led_drive_unit.sv]
// ============================================================================
// tb_hue_rotate_rgb_led_drive_unit
// Self-checking bench for the hue rotation LED drive unit. A queue-fed driver
// offers direct colours and hue rotations with random gaps, a receiver stalls
// at random (once for a long stretch), and every result transfer is checked
// against levels predicted from a Q2.14 cos/sin table built here, under both
// LED polarities set over the APB port.
// ============================================================================
module tb_hue_rotate_rgb_led_drive_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hrl_pkg::*;

    localparam int          FRAC       = 14;
    localparam longint      UNIT       = longint'(1) << FRAC;
    localparam longint      HALF_UNIT  = longint'(1) << (FRAC - 1);
    localparam longint      PROD_SCALE = longint'(1) << (2 * FRAC);
    localparam longint unsigned PI_28  = 64'd843314857;
    localparam longint unsigned ONE_28 = 64'd1 << 28;
    localparam int          HOLD_CYCLES    = 200;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [ADDR_W-1:0] POLARITY_ADDR = ADDR_W'(4 * int'(REG_COMMON_CATHODE));

    typedef struct packed {
        logic        op;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [8:0]  hue;
        logic [7:0]  br;
        logic [3:0]  gap;
    } led_cmd_t;

    // index 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [2:0][7:0] level;
        logic [2:0]      changed;
    } led_levels_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_op = OP_DIRECT;
    logic signed [DIRECT_W-1:0] i_red_in = '0;
    logic signed [DIRECT_W-1:0] i_green_in = '0;
    logic signed [DIRECT_W-1:0] i_blue_in = '0;
    logic [HUE_W-1:0]           i_hue_degrees = '0;
    logic [BR_W-1:0]            i_brightness = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [LEVEL_W-1:0]         o_red_level;
    logic [LEVEL_W-1:0]         o_green_level;
    logic [LEVEL_W-1:0]         o_blue_level;
    logic                       o_red_changed;
    logic                       o_green_changed;
    logic                       o_blue_changed;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [APB_DW-1:0]          pwdata = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    hue_rotate_rgb_led_drive_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    led_cmd_t    pending_cmds[$];
    led_levels_t expected_levels[$];
    longint      cos_lut [0:90];
    longint      sin_lut [0:90];
    logic [7:0]  shadow_level [3];
    logic        polarity_pass = 1'b1;
    int          issued_cnt = 0;
    int          accepted_cnt = 0;
    int          error_cnt = 0;
    int          idle_cycles = 0;
    int          hold_asks = 0;
    logic        in_xfer = 1'b0;
    logic        out_xfer = 1'b0;

    // ------------------------------------------------------------------------
    // Level prediction
    // ------------------------------------------------------------------------
    function automatic longint round_to_lut(longint unsigned v);
        if (v > (64'd1 << 63)) v = 0;
        if (v > ONE_28) v = ONE_28;
        return longint'((v + (64'd1 << (27 - FRAC))) >> (28 - FRAC));
    endfunction

    // Taylor series in Q28, each term truncated, then rounded to the table
    task automatic build_trig_luts();
        longint unsigned x, ct, cs, st, ss;
        for (int d = 0; d <= 90; d++) begin
            x  = (64'(d) * PI_28 + 64'd90) / 64'd180;
            ct = ONE_28;
            cs = ONE_28;
            st = x;
            ss = x;
            for (longint unsigned k = 1; k <= 10; k++) begin
                ct = ((ct * x) >> 28) / ((2 * k - 1) * (2 * k));
                st = ((st * x) >> 28) / ((2 * k) * (2 * k + 1));
                if (k[0]) begin
                    cs -= ct;
                    ss -= st;
                end else begin
                    cs += ct;
                    ss += st;
                end
            end
            cos_lut[d] = round_to_lut(cs);
            sin_lut[d] = round_to_lut(ss);
        end
    endtask

    function automatic logic [7:0] drive_level(longint v, logic pass);
        logic [7:0] u;
        if (v < 0) u = 8'd0;
        else if (v > 255) u = LEVEL_MAX;
        else u = v[7:0];
        return pass ? u : LEVEL_MAX - u;
    endfunction

    task automatic predict_levels(input led_cmd_t c);
        longint      lv [3];
        longint      cv, sv, base, br, k60;
        int          ang;
        led_levels_t e;
        if (c.op == OP_HUE) begin
            ang = int'(c.hue) % 360;
            if (ang <= 90) begin
                cv = cos_lut[ang];        sv = sin_lut[ang];
            end else if (ang <= 180) begin
                cv = -cos_lut[180 - ang]; sv = sin_lut[180 - ang];
            end else if (ang <= 270) begin
                cv = -cos_lut[ang - 180]; sv = -sin_lut[ang - 180];
            end else begin
                cv = cos_lut[360 - ang];  sv = -sin_lut[360 - ang];
            end
            br    = longint'(c.br);
            k60   = sin_lut[60];
            base  = HALF_UNIT * UNIT - cv * HALF_UNIT;
            lv[0] = (HALF_UNIT * UNIT + cv * UNIT) * br / PROD_SCALE;
            lv[1] = (base + k60 * sv) * br / PROD_SCALE;
            lv[2] = (base - k60 * sv) * br / PROD_SCALE;
        end else begin
            lv[0] = longint'($signed(c.red));
            lv[1] = longint'($signed(c.green));
            lv[2] = longint'($signed(c.blue));
        end
        for (int i = 0; i < 3; i++) begin
            e.level[i]   = drive_level(lv[i], polarity_pass);
            e.changed[i] = (e.level[i] != shadow_level[i]);
            shadow_level[i] = e.level[i];
        end
        expected_levels.push_back(e);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued items after their gap, hold until transfer
    // ------------------------------------------------------------------------
    int   gap_left = 0;
    logic gap_armed = 1'b0;

    always @(negedge i_clk) begin
        led_cmd_t c;
        logic     nxt_valid;
        nxt_valid = i_in_valid;
        if (i_rst_n && !(i_in_valid && !in_xfer)) begin
            nxt_valid = 1'b0;
            if (pending_cmds.size() != 0 && !gap_armed) begin
                gap_left  = pending_cmds[0].gap;
                gap_armed = 1'b1;
            end
            if (gap_armed && gap_left == 0) begin
                c = pending_cmds.pop_front();
                gap_armed     = 1'b0;
                nxt_valid     = 1'b1;
                i_op          <= c.op;
                i_red_in      <= c.red;
                i_green_in    <= c.green;
                i_blue_in     <= c.blue;
                i_hue_degrees <= c.hue;
                i_brightness  <= c.br;
            end else if (gap_armed) begin
                gap_left--;
            end
        end
        i_in_valid <= nxt_valid;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall per result, calm stretches, one long hold-off
    // ------------------------------------------------------------------------
    int   stall_left = 0;
    int   hold_left = 0;
    int   hold_seen = 0;
    int   rx_count = 0;
    logic rx_calm = 1'b0;

    always @(negedge i_clk) begin
        logic rdy;
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (out_xfer) begin
            stall_left = rx_calm ? 0 : $urandom_range(0, 14);
            rx_count++;
            if (rx_count % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        end
        rdy = 1'b0;
        if (!i_rst_n) rdy = 1'b0;
        else if (hold_left > 0) hold_left--;
        else if (stall_left > 0) stall_left--;
        else rdy = 1'b1;
        i_out_ready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input transfer, check on result transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        led_cmd_t    c;
        led_levels_t got, exp_l;
        string       chan [3];
        chan = '{"red", "green", "blue"};
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr == POLARITY_ADDR)
                polarity_pass = pwdata[0];
            if (i_in_valid && o_in_ready) begin
                c = '{op: i_op, red: i_red_in, green: i_green_in, blue: i_blue_in,
                      hue: i_hue_degrees, br: i_brightness, gap: 4'd0};
                predict_levels(c);
                accepted_cnt++;
            end
            if (o_out_valid && i_out_ready) begin
                got.level   = {o_blue_level, o_green_level, o_red_level};
                got.changed = {o_blue_changed, o_green_changed, o_red_changed};
                if (expected_levels.size() == 0) begin
                    $display("%0t: unexpected result levels r=%0d g=%0d b=%0d",
                             $time, o_red_level, o_green_level, o_blue_level);
                    error_cnt++;
                end else begin
                    exp_l = expected_levels.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (got.level[i] !== exp_l.level[i]) begin
                            $display("%0t: %s level expected %0d actual %0d",
                                     $time, chan[i], exp_l.level[i], got.level[i]);
                            error_cnt++;
                        end
                        if (got.changed[i] !== exp_l.changed[i]) begin
                            $display("%0t: %s changed expected %0b actual %0b",
                                     $time, chan[i], exp_l.changed[i], got.changed[i]);
                            error_cnt++;
                        end
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        in_xfer  <= i_in_valid && o_in_ready;
        out_xfer <= o_out_valid && i_out_ready;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic tx_calm = 1'b0;
    int   tx_count = 0;

    task automatic queue_cmd(input logic op, input int r, input int g, input int b,
                             input int hue, input int br);
        led_cmd_t c;
        c.op    = op;
        c.red   = 16'(r);
        c.green = 16'(g);
        c.blue  = 16'(b);
        c.hue   = 9'(hue);
        c.br    = 8'(br);
        c.gap   = 4'($urandom_range(0, 14));
        pending_cmds.push_back(c);
        issued_cnt++;
    endtask

    function automatic logic [15:0] random_direct();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom);
            1:       return 16'd0;
            2:       return 16'd255;
            default: return 16'($signed($urandom_range(0, 340)) - 40);
        endcase
    endfunction

    // flood: first items back to back so the long hold-off backs up the input
    task automatic queue_random_cmds(input int n, input bit flood);
        led_cmd_t c, prev;
        prev = '0;
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 4) == 0) begin
                c = prev;
            end else begin
                c.op    = $urandom_range(0, 1) ? OP_HUE : OP_DIRECT;
                c.red   = random_direct();
                c.green = random_direct();
                c.blue  = random_direct();
                c.hue   = 9'($urandom_range(0, 360));
                case ($urandom_range(0, 9))
                    0:       c.br = 8'd0;
                    1:       c.br = 8'd255;
                    default: c.br = 8'($urandom);
                endcase
            end
            if (tx_count % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
            tx_count++;
            c.gap = (tx_calm || (flood && i < 40)) ? 4'd0 : 4'($urandom_range(0, 14));
            pending_cmds.push_back(c);
            issued_cnt++;
            prev = c;
        end
    endtask

    task automatic wait_drained();
        while (accepted_cnt != issued_cnt || expected_levels.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_polarity(input logic pass);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= POLARITY_ADDR;
        pwdata  <= APB_DW'(pass);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // read back
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== APB_DW'(pass)) begin
            $display("%0t: polarity readback expected %0h actual %0h",
                     $time, APB_DW'(pass), prdata);
            error_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        build_trig_luts();
        for (int i = 0; i < 3; i++) shadow_level[i] = 8'd0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_polarity(1'b1);
        // directed: saturation edges, repeat with no change, quadrant points
        queue_cmd(OP_DIRECT, 0, 0, 0, 300, 200);
        queue_cmd(OP_DIRECT, 255, 256, -1, 0, 0);
        queue_cmd(OP_DIRECT, 32767, -32768, 254, 0, 0);
        queue_cmd(OP_DIRECT, -32768, 32767, 1, 511, 255);
        queue_cmd(OP_DIRECT, 128, 128, 128, 0, 0);
        queue_cmd(OP_DIRECT, 128, 128, 128, 0, 0);
        queue_cmd(OP_HUE, 0, 0, 0, 0, 255);
        queue_cmd(OP_HUE, -1, 32767, -32768, 30, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 60, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 90, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 120, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 180, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 240, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 270, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 300, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 359, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 360, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 0, 255);
        queue_cmd(OP_HUE, 0, 0, 0, 45, 0);
        queue_cmd(OP_HUE, 0, 0, 0, 150, 1);
        queue_cmd(OP_HUE, 0, 0, 0, 210, 128);
        queue_cmd(OP_HUE, 0, 0, 0, 256, 127);
        wait_drained();

        set_polarity(1'b0);
        queue_random_cmds(300, 1'b0);
        wait_drained();

        set_polarity(1'b1);
        queue_random_cmds(300, 1'b1);
        hold_asks++;
        wait_drained();

        set_polarity(1'b0);
        queue_random_cmds(175, 1'b0);
        wait_drained();

        set_polarity(1'b1);
        queue_random_cmds(175, 1'b0);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (error_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
